>>> hw/rtl/depq_pkg.sv
`default_nettype none
package depq_pkg;
   localparam int DefCapacity = 64;
   localparam int ValueWidth = 32;
   localparam int OpWidth = 2;
   localparam int CountOutWidth = 7;
   localparam int StatusWidth = 2;

   localparam logic [OpWidth-1:0] OP_INSERT  = 2'd0;
   localparam logic [OpWidth-1:0] OP_DEL_MAX = 2'd1;
   localparam logic [OpWidth-1:0] OP_DEL_MIN = 2'd2;

   localparam logic [StatusWidth-1:0] ST_DONE  = 2'd0;
   localparam logic [StatusWidth-1:0] ST_EMPTY = 2'd1;
   localparam logic [StatusWidth-1:0] ST_FULL  = 2'd2;

   typedef logic signed [ValueWidth-1:0] value_type;
endpackage
`default_nettype wire

>>> hw/rtl/depq_if.sv
`default_nettype none
interface depq_req_if import depq_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [OpWidth-1:0]    operation;
   value_type             value;
   modport source (output valid, operation, value, input ready);
   modport sink   (input valid, operation, value, output ready);
endinterface

interface depq_rsp_if import depq_pkg::*; ();
   logic                     valid;
   logic                     ready;
   value_type                max_value;
   value_type                min_value;
   logic [CountOutWidth-1:0] entry_count;
   logic [StatusWidth-1:0]   status;
   modport source (output valid, max_value, min_value, entry_count, status, input ready);
   modport sink   (input valid, max_value, min_value, entry_count, status, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/double_ended_priority_queue_top.sv
// double-ended priority queue over signed 32-bit values
// req channel: operation (insert, delete max, delete min) and value.
// rsp channel: one item per request with max, min, count and status.
// values sit unordered in a 1-read 1-write memory of CAPACITY entries.
// a delete first scans the memory for the extreme (one entry a cycle),
// then moves the last entry into the freed slot. after each change the
// max and min are found by another scan of all held entries.
// an insert writes the value and then scans; a delete runs the find scan,
// the move and then the scan; a full insert, an unknown op or an empty delete
// only scans. the memory read port paces the scans, one entry per cycle. the
// next item is taken in the cycle after the result is taken.
// reset clears the count and the control; memory contents need no clear.
// one item is in work at a time; req ready is low until the result is
// taken from the output register, so a stalled receiver holds the block.
`default_nettype none
module double_ended_priority_queue_top import depq_pkg::*; #(
   parameter int CAPACITY = DefCapacity
) (
   input wire logic   clock,
   input wire logic   reset,
   depq_req_if.sink   req,
   depq_rsp_if.source rsp
);
   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_FIND = 3'd1;
   localparam logic [2:0] S_MOVE = 3'd2;
   localparam logic [2:0] S_SCAN = 3'd3;
   localparam logic [2:0] S_OUT  = 3'd4;

   value_type mem [CAPACITY];
   value_type rd_data_ff;

   logic [2:0]             state_ff, state_in;
   logic [CW-1:0]          count_ff, count_in;
   logic [CW-1:0]          idx_ff, idx_in;      // address issued
   logic                   rvalid_ff, rvalid_in;
   logic [AW-1:0]          raddr_ff, raddr_in;  // address of rd_data
   logic                   want_max_ff, want_max_in;
   logic [AW-1:0]          best_ff, best_in;
   value_type              max_ff, max_in, min_ff, min_in;
   logic [StatusWidth-1:0] status_ff, status_in;
   logic                   rvalid_d_ff;

   logic          we;
   logic [AW-1:0] waddr;
   value_type     wdata;
   logic [AW-1:0] rd_addr;
   logic          rd_en;

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      if (rd_en) rd_data_ff <= mem[rd_addr];
   end

   assign req.ready       = (state_ff == S_IDLE);
   assign rsp.valid       = (state_ff == S_OUT);
   assign rsp.max_value   = (count_ff == '0) ? '0 : max_ff;
   assign rsp.min_value   = (count_ff == '0) ? '0 : min_ff;
   assign rsp.entry_count = CountOutWidth'(count_ff);
   assign rsp.status      = status_ff;

   always_comb begin
      state_in = state_ff; count_in = count_ff; idx_in = idx_ff;
      rvalid_in = 1'b0; raddr_in = raddr_ff; want_max_in = want_max_ff;
      best_in = best_ff; max_in = max_ff; min_in = min_ff; status_in = status_ff;
      we = 1'b0; waddr = '0; wdata = req.value;
      rd_en = 1'b0; rd_addr = AW'(idx_ff);
      unique case (state_ff)
         S_IDLE: begin
            if (req.valid) begin
               status_in = ST_DONE;
               idx_in = '0;
               unique case (req.operation)
                  OP_INSERT: begin
                     if (count_ff >= CW'(CAPACITY)) status_in = ST_FULL;
                     else begin
                        we = 1'b1; waddr = AW'(count_ff);
                        count_in = count_ff + 1'b1;
                     end
                     state_in = S_SCAN;
                  end
                  OP_DEL_MAX, OP_DEL_MIN: begin
                     want_max_in = (req.operation == OP_DEL_MAX);
                     if (count_ff == '0) begin
                        status_in = ST_EMPTY; state_in = S_SCAN;
                     end else state_in = S_FIND;
                  end
                  default: state_in = S_SCAN;
               endcase
            end
         end
         S_FIND, S_SCAN: begin
            // issue one read a cycle, fold each read's data in the cycle after it is issued
            if (idx_ff < count_ff) begin
               rd_en = 1'b1; rvalid_in = 1'b1; raddr_in = AW'(idx_ff);
               idx_in = idx_ff + 1'b1;
            end
            if (rvalid_ff) begin
               if (state_ff == S_FIND) begin
                  if (raddr_ff == '0 ||
                      (want_max_ff ? (rd_data_ff > max_ff) : (rd_data_ff < max_ff))) begin
                     max_in = rd_data_ff; best_in = raddr_ff;
                  end
               end else begin
                  if (raddr_ff == '0 || rd_data_ff > max_ff) max_in = rd_data_ff;
                  if (raddr_ff == '0 || rd_data_ff < min_ff) min_in = rd_data_ff;
               end
            end
            if (idx_ff >= count_ff && !rvalid_ff) begin
               if (state_ff == S_FIND) begin
                  // read the last entry for the move
                  rd_en = 1'b1; rd_addr = AW'(count_ff - 1'b1);
                  state_in = S_MOVE;
               end else state_in = S_OUT;
            end
         end
         S_MOVE: begin
            if (rvalid_d_ff) begin
               we = 1'b1; waddr = best_ff; wdata = rd_data_ff;
               count_in = count_ff - 1'b1;
               idx_in = '0;
               state_in = S_SCAN;
            end
         end
         S_OUT: if (rsp.ready) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; count_ff <= '0; rvalid_ff <= 1'b0; rvalid_d_ff <= 1'b0;
      end else begin
         state_ff <= state_in; count_ff <= count_in; rvalid_ff <= rvalid_in;
         rvalid_d_ff <= (state_ff == S_FIND) && (state_in == S_MOVE);
      end
      idx_ff <= idx_in; raddr_ff <= raddr_in; want_max_ff <= want_max_in;
      best_ff <= best_in; max_ff <= max_in; min_ff <= min_in; status_ff <= status_in;
   end
endmodule
`default_nettype wire

>>> test/testbench_if.sv
`timescale 1ns / 1ps
// channel interfaces come with the rtl (depq_req_if, depq_rsp_if); this file
// holds the receiver stall pattern helper shared by the testbench
package testbench_pkg;
   function automatic bit stall_pattern(input int unsigned cycle, input int unsigned mode);
      case (mode)
         0: return 1'b0;
         1: return (cycle % 7) < 3;
         2: return (cycle % 13) == 5;
         default: return ($urandom_range(0, 3) == 0);
      endcase
   endfunction
endpackage

>>> test/testbench.sv
`timescale 1ns / 1ps
module testbench;
   import depq_pkg::*;
   import testbench_pkg::*;

   localparam int Capacity = DefCapacity;
   localparam int WatchdogLimit = 20000;
   // operation code with no defined action
   localparam logic [OpWidth-1:0] OP_UNUSED = 2'd3;

   typedef struct packed {
      value_type                max_value;
      value_type                min_value;
      logic [CountOutWidth-1:0] entry_count;
      logic [StatusWidth-1:0]   status;
   } queue_report_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   depq_req_if req ();
   depq_rsp_if rsp ();

   double_ended_priority_queue_top #(.CAPACITY(Capacity)) i_dut (
      .clock(clock),
      .reset(reset),
      .req  (req.sink),
      .rsp  (rsp.source)
   );

   always #4 clock = ~clock;

   // predictor state: unordered multiset of held values
   value_type        held_values[$];
   queue_report_type pending_reports[$];
   int               mismatch_count = 0;
   int               report_count = 0;
   int               sent_count = 0;
   int               idle_cycles = 0;
   int unsigned      stall_mode = 0;
   int unsigned      cycle_count = 0;
   int               full_hits = 0;
   int               empty_hits = 0;

   function automatic queue_report_type predict_report(input logic [OpWidth-1:0] operation,
                                                       input value_type value);
      queue_report_type report;
      int               pick;
      report.status = ST_DONE;
      if (operation == OP_INSERT) begin
         if (held_values.size() >= Capacity) begin
            report.status = ST_FULL;
         end else begin
            held_values.push_back(value);
         end
      end else if (operation == OP_DEL_MAX || operation == OP_DEL_MIN) begin
         if (held_values.size() == 0) begin
            report.status = ST_EMPTY;
         end else begin
            pick = 0;
            foreach (held_values[i]) begin
               if (operation == OP_DEL_MAX ? held_values[i] > held_values[pick]
                                           : held_values[i] < held_values[pick]) begin
                  pick = i;
               end
            end
            held_values.delete(pick);
         end
      end
      report.max_value = 0;
      report.min_value = 0;
      if (held_values.size() != 0) begin
         report.max_value = held_values[0];
         report.min_value = held_values[0];
         foreach (held_values[i]) begin
            if (held_values[i] > report.max_value) begin
               report.max_value = held_values[i];
            end
            if (held_values[i] < report.min_value) begin
               report.min_value = held_values[i];
            end
         end
      end
      report.entry_count = CountOutWidth'(held_values.size());
      return report;
   endfunction

   initial begin
      req.valid     = 1'b0;
      req.operation = OP_INSERT;
      req.value     = '0;
      rsp.ready     = 1'b0;
   end

   task automatic send_item(input logic [OpWidth-1:0] operation, input value_type value);
      req.valid     <= 1'b1;
      req.operation <= operation;
      req.value     <= value;
      @(posedge clock);
      while (!req.ready) begin
         @(posedge clock);
      end
      pending_reports.push_back(predict_report(operation, value));
      sent_count++;
   endtask

   // bursts of random length, a random gap (sometimes none) in between; valid held high inside a burst
   int burst_left = 0;
   task automatic send_paced(input logic [OpWidth-1:0] operation, input value_type value);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
         if (gap != 0) begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      send_item(operation, value);
   endtask

   task automatic end_burst();
      req.valid <= 1'b0;
      burst_left = 0;
   endtask

   function automatic value_type random_value();
      case ($urandom_range(0, 5))
         0: return value_type'(32'h8000_0000 + $urandom_range(0, 3));
         1: return value_type'(32'h7fff_ffff - $urandom_range(0, 3));
         2: return value_type'($urandom_range(0, 8)) - 4;
         default: return value_type'($urandom());
      endcase
   endfunction

   task automatic test_directed_edges();
      send_paced(OP_DEL_MAX, '0);
      send_paced(OP_DEL_MIN, 32'h1234_5678);
      send_paced(OP_INSERT, 32'sh7fff_ffff);
      send_paced(OP_INSERT, 32'sh8000_0000);
      send_paced(OP_INSERT, 32'sh7fff_ffff);
      send_paced(OP_INSERT, -1);
      send_paced(OP_INSERT, 0);
      send_paced(OP_INSERT, 32'sh8000_0000);
      send_paced(OP_UNUSED, 32'h5555_aaaa);
      send_paced(OP_DEL_MAX, '0);
      send_paced(OP_DEL_MAX, '0);
      send_paced(OP_DEL_MIN, '0);
      send_paced(OP_DEL_MIN, '0);
      send_paced(OP_DEL_MAX, '0);
      send_paced(OP_DEL_MIN, '0);
      send_paced(OP_DEL_MIN, '0);
      send_paced(OP_UNUSED, 32'haaaa_5555);
      end_burst();
   endtask

   // fill to capacity, overflow, then drain past empty
   task automatic test_fill_and_drain();
      repeat (Capacity + 2) begin
         send_paced(OP_INSERT, random_value());
      end
      repeat (Capacity / 2 + 1) begin
         send_paced(OP_DEL_MAX, value_type'($urandom()));
         send_paced(OP_DEL_MIN, value_type'($urandom()));
      end
      end_burst();
   endtask

   task automatic test_random_mix(input int count);
      int  roll;
      bit  filling;
      logic [OpWidth-1:0] operation;
      filling = 1'b1;
      for (int n = 0; n < count; n++) begin
         if (n % 60 == 0) begin
            stall_mode = $urandom_range(0, 3);
         end
         if (held_values.size() >= Capacity - 1) filling = 1'b0;
         if (held_values.size() <= 1) filling = 1'b1;
         roll = $urandom_range(0, 19);
         if (roll == 0) operation = OP_UNUSED;
         else if (roll < (filling ? 13 : 6)) operation = OP_INSERT;
         else operation = roll[0] ? OP_DEL_MAX : OP_DEL_MIN;
         send_paced(operation, random_value());
      end
      end_burst();
   endtask

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      rsp.ready <= reset ? 1'b0 : !stall_pattern(cycle_count, stall_mode);
   end

   always @(posedge clock) begin
      queue_report_type seen;
      queue_report_type want;
      if (!reset && rsp.valid && rsp.ready) begin
         seen = '{rsp.max_value, rsp.min_value, rsp.entry_count, rsp.status};
         report_count++;
         if (pending_reports.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) $display("unexpected item: %p", seen);
         end else begin
            want = pending_reports.pop_front();
            if (want.status == ST_FULL) full_hits++;
            if (want.status == ST_EMPTY) empty_hits++;
            if (seen !== want) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("mismatch item %0d: expected max %0d min %0d count %0d status %0d",
                           report_count, want.max_value, want.min_value, want.entry_count,
                           want.status);
                  $display("                 got      max %0d min %0d count %0d status %0d",
                           seen.max_value, seen.min_value, seen.entry_count, seen.status);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || reset) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WatchdogLimit) begin
         $display("watchdog: nothing accepted for %0d cycles", idle_cycles);
         $display("FAIL");
         $finish;
      end
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_edges();
      stall_mode = 3;
      test_fill_and_drain();
      test_random_mix(500);
      while (pending_reports.size() != 0) begin
         @(posedge clock);
      end
      repeat (2 * Capacity + 20) @(posedge clock);
      $display("sent %0d items, checked %0d results", sent_count, report_count);
      $display("full-store drops %0d, empty deletes %0d, mismatches %0d",
               full_hits, empty_hits, mismatch_count);
      if (mismatch_count == 0 && pending_reports.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end
endmodule

>>> double_ended_priority_queue_top.f
hw/rtl/depq_pkg.sv
hw/rtl/depq_if.sv
hw/rtl/double_ended_priority_queue_top.sv
test/testbench_if.sv
test/testbench.sv
